// ===== design/gdpg_pkg.sv =====
// Shared types, widths and constants of the Gaussian pixel generator.
// Also holds the elaboration-time builder for the 2^-x fraction table.
// No dependencies.
package gdpg_pkg;

  // Field widths of the pixel coordinate and the configuration registers.
  localparam int COORD_W     = 12;
  localparam int CENTRE_W    = 21;
  localparam int CENTRE_FRAC = 8;
  localparam int INV_W       = 24;
  localparam int PIX_W       = 32;
  localparam int DIM_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Largest frame dimension for which the end-of-row and end-of-frame flags fire.
  localparam int MAX_DIM = 4096;

  // Default number of entries in the exponent fraction table.
  localparam int EXP_TABLE_SIZE_DEF = 256;

  // Internal widths.
  localparam int DIFF_W = COORD_W + CENTRE_FRAC + 3;  // signed coordinate minus centre
  localparam int ABS_W  = DIFF_W - 1;                 // its magnitude
  localparam int Z_W    = 21;                         // normalised distance, clipped to 16.0
  localparam int T_W    = 25;                         // half the squared radius, Q.16
  localparam int K_W    = 10;                         // integer part of the base-2 exponent
  localparam int EXP_W  = 17;                         // table entries and shifted factor
  localparam int PROD_W = PIX_W + EXP_W;              // height times factor

  localparam logic [Z_W-1:0]  Z_CLIP      = Z_W'(21'h100000);
  localparam logic [16:0]     LOG2E_Q16   = 17'd94548;
  localparam logic [29:0]     INV_2PI_Q32 = 30'd683565276;
  localparam logic [63:0]     LN2_Q32     = 64'd2977044472;

  localparam logic signed [PIX_W-1:0] PIX_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 32'sh8000_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS      = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } pix_in_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_value;
    logic                    saturated;
    logic                    last_in_row;
    logic                    last_in_frame;
  } pix_out_t;

  typedef struct packed {
    logic last_in_row;
    logic last_in_frame;
  } edge_flags_t;

  // round(2^16 * 2^-x) for x = xq / 2^32, by a truncated series of exp(-x*ln2).
  // Only ever called with constant arguments.
  function automatic logic [EXP_W-1:0] exp_entry(input logic [63:0] xq);
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] sum;
    a    = (xq * LN2_Q32) >> 32;
    term = 64'd1 << 32;
    sum  = term;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * a) >> 32) / 64'(n);
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return EXP_W'((sum + 64'd32768) >> 16);
  endfunction

endpackage

// ===== design/gdpg_axis.sv =====
// Distance along one axis: |coordinate - centre| scaled by 1/sigma, clipped.
// Two register stages. Depends on gdpg_pkg.
module gdpg_axis import gdpg_pkg::*; (
  input  logic                       clk_i,
  input  logic [COORD_W-1:0]         coord_i,
  input  logic signed [CENTRE_W-1:0] centre_i,
  input  logic [INV_W-1:0]           inv_i,
  output logic [Z_W-1:0]             z_o
);

  logic signed [DIFF_W-1:0]      diff;
  logic [ABS_W-1:0]              abs_d, abs_q;
  logic [ABS_W+INV_W-1:0]        scaled;
  logic [ABS_W+INV_W-9:0]        z_full;
  logic [Z_W-1:0]                z_d, z_q;

  assign diff  = $signed({3'b000, coord_i, {CENTRE_FRAC{1'b0}}}) - DIFF_W'(centre_i);
  assign abs_d = diff[DIFF_W-1] ? ABS_W'(-diff) : ABS_W'(diff);

  assign scaled = abs_q * inv_i;
  assign z_full = scaled[ABS_W+INV_W-1:8];
  // Beyond 16.0 the exponential is already zero, so the distance saturates there.
  assign z_d    = (z_full > (ABS_W+INV_W-8)'(Z_CLIP)) ? Z_CLIP : z_full[Z_W-1:0];

  always_ff @(posedge clk_i) begin
    abs_q <= abs_d;
    z_q   <= z_d;
  end

  assign z_o = z_q;

endmodule

// ===== design/gdpg_exp.sv =====
// Radius to Gaussian factor: squares, halving, log2(e) scaling, table lookup, shift.
// Five register stages including the registered table read. Depends on gdpg_pkg.
module gdpg_exp import gdpg_pkg::*; #(
  parameter int EXP_TABLE_SIZE = EXP_TABLE_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic [Z_W-1:0]   zy_i,
  input  logic [Z_W-1:0]   zx_i,
  output logic [EXP_W-1:0] g_o
);

  localparam int IDX_W  = $clog2(EXP_TABLE_SIZE);
  localparam int SIZE_W = $clog2(EXP_TABLE_SIZE + 1);

  logic [EXP_W-1:0]        rom_w [EXP_TABLE_SIZE];
  logic [2*Z_W-1:0]        sq_y_q, sq_x_q;
  logic [2*Z_W-1:0]        sq_sum;
  logic [T_W-1:0]          t_q;
  logic [T_W+16:0]         e_w;
  logic [K_W-1:0]          k_q, k2_q;
  logic [15:0]             f_q;
  logic [16+SIZE_W-1:0]    idx_full;
  logic [IDX_W-1:0]        idx;
  logic [EXP_W-1:0]        rom_q;
  logic [EXP_W-1:0]        g_d, g_q;

  // Entry i holds round(2^16 * 2^(-i/EXP_TABLE_SIZE)).
  for (genvar gi = 0; gi < EXP_TABLE_SIZE; gi++) begin : g_rom
    localparam logic [63:0] XQ = (64'(gi) << 32) / EXP_TABLE_SIZE;
    assign rom_w[gi] = exp_entry(XQ);
  end

  assign sq_sum = sq_y_q + sq_x_q;
  assign e_w    = t_q * LOG2E_Q16;

  assign idx_full = f_q * SIZE_W'(EXP_TABLE_SIZE);
  assign idx      = idx_full[16 +: IDX_W];

  // Table entries are below 2^17, so any larger shift gives zero.
  assign g_d = (k2_q >= K_W'(EXP_W)) ? '0 : (rom_q >> k2_q);

  always_ff @(posedge clk_i) begin
    sq_y_q <= zy_i * zy_i;
    sq_x_q <= zx_i * zx_i;
    t_q    <= sq_sum[2*Z_W-1:17];
    k_q    <= e_w[32 +: K_W];
    f_q    <= e_w[31:16];
    rom_q  <= rom_w[idx];
    k2_q   <= k_q;
    g_q    <= g_d;
  end

  assign g_o = g_q;

endmodule

// ===== design/gdpg_height.sv =====
// Peak height: the register value, or 1/(2*pi*sigma_y*sigma_x) when it is zero.
// Three register stages fed from configuration only. Depends on gdpg_pkg.
module gdpg_height import gdpg_pkg::*; (
  input  logic                    clk_i,
  input  logic [INV_W-1:0]        inv_row_i,
  input  logic [INV_W-1:0]        inv_col_i,
  input  logic signed [PIX_W-1:0] peak_i,
  output logic signed [PIX_W-1:0] height_o
);

  logic [2*INV_W-1:0]      p_q;
  logic [61:0]             hi_q;
  logic [45:0]             lo_w;
  logic [29:0]             lo_q;
  logic [62:0]             norm_sum;
  logic signed [PIX_W-1:0] height_d, height_q;

  assign lo_w     = p_q[15:0] * INV_2PI_Q32;
  assign norm_sum = {1'b0, hi_q} + 63'(lo_q);
  assign height_d = (peak_i != '0) ? peak_i : $signed({1'b0, norm_sum[62:32]});

  always_ff @(posedge clk_i) begin
    p_q      <= inv_row_i * inv_col_i;
    hi_q     <= p_q[2*INV_W-1:16] * INV_2PI_Q32;
    lo_q     <= lo_w[45:16];
    height_q <= height_d;
  end

  assign height_o = height_q;

endmodule

// ===== design/gaussian_2d_pixel_generator.sv =====
// Top level of the elliptical 2-D Gaussian pixel generator: configuration registers,
// valid pipeline, final scaling and saturation. Depends on gdpg_pkg, gdpg_axis,
// gdpg_exp and gdpg_height.
//
//  channel   | dir | handshake                         | beat
//  ----------+-----+-----------------------------------+-------------------------
//  pixel in  | in  | start & !busy                     | pix_i (row, col)
//  result    | out | res_valid_o, one cycle, no stall  | res_o (value, flags)
//  config    | in  | cfg_we_i                          | cfg_idx_i, cfg_data_i
//
// One pixel enters every cycle; busy is never raised. Each result passes through
// nine register stages, from the distance multipliers through the table read to
// the final add. Reset clears the valid pipeline and returns the registers to
// their defaults; nothing needs a sweep. Results leave as a single-cycle strobe,
// so nothing inside ever waits.
module gaussian_2d_pixel_generator import gdpg_pkg::*; #(
  parameter int EXP_TABLE_SIZE = EXP_TABLE_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pix_in_t               pix_i,
  output logic                  res_valid_o,
  output pix_out_t              res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LAT = 9;

  logic signed [CENTRE_W-1:0] center_row_q, center_col_q;
  logic [INV_W-1:0]           inv_row_q, inv_col_q;
  logic signed [PIX_W-1:0]    peak_q, background_q;
  logic [DIM_W-1:0]           num_cols_q, num_rows_q;

  logic                       accept;
  logic [LAT-1:0]             valid_q;
  edge_flags_t                flags_d;
  edge_flags_t                flags_q [LAT];

  logic [Z_W-1:0]             zy, zx;
  logic [EXP_W-1:0]           g;
  logic signed [PIX_W-1:0]    height;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [PIX_W+1:0]    sum_w;
  logic                       sat_hi, sat_lo;
  logic signed [PIX_W-1:0]    value_d, value_q;
  logic                       sat_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_row_q <= '0;
      center_col_q <= '0;
      inv_row_q    <= INV_W'(65536);
      inv_col_q    <= INV_W'(65536);
      peak_q       <= '0;
      background_q <= '0;
      num_cols_q   <= DIM_W'(4096);
      num_rows_q   <= DIM_W'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_ROW:    center_row_q <= cfg_data_i[CENTRE_W-1:0];
        REG_CENTER_COL:    center_col_q <= cfg_data_i[CENTRE_W-1:0];
        REG_INV_SIGMA_ROW: inv_row_q    <= cfg_data_i[INV_W-1:0];
        REG_INV_SIGMA_COL: inv_col_q    <= cfg_data_i[INV_W-1:0];
        REG_PEAK_HEIGHT:   peak_q       <= cfg_data_i[PIX_W-1:0];
        REG_BACKGROUND:    background_q <= cfg_data_i[PIX_W-1:0];
        REG_NUM_COLS:      num_cols_q   <= cfg_data_i[DIM_W-1:0];
        REG_NUM_ROWS:      num_rows_q   <= cfg_data_i[DIM_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], accept};
    end
  end

  // A dimension of zero or above the maximum never raises its flag.
  assign flags_d.last_in_row = (num_cols_q != '0) && (num_cols_q <= DIM_W'(MAX_DIM))
                               && ({1'b0, pix_i.col} == num_cols_q - DIM_W'(1));
  assign flags_d.last_in_frame = flags_d.last_in_row && (num_rows_q != '0)
                                 && (num_rows_q <= DIM_W'(MAX_DIM))
                                 && ({1'b0, pix_i.row} == num_rows_q - DIM_W'(1));

  always_ff @(posedge clk_i) begin
    flags_q[0] <= flags_d;
    for (int i = 1; i < LAT; i++) begin
      flags_q[i] <= flags_q[i-1];
    end
  end

  gdpg_axis u_axis_row (
    .clk_i    (clk_i),
    .coord_i  (pix_i.row),
    .centre_i (center_row_q),
    .inv_i    (inv_row_q),
    .z_o      (zy)
  );

  gdpg_axis u_axis_col (
    .clk_i    (clk_i),
    .coord_i  (pix_i.col),
    .centre_i (center_col_q),
    .inv_i    (inv_col_q),
    .z_o      (zx)
  );

  gdpg_exp #(
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_exp (
    .clk_i (clk_i),
    .zy_i  (zy),
    .zx_i  (zx),
    .g_o   (g)
  );

  // The height follows the registers continuously; it has settled long before
  // any pixel accepted after a register write reaches the product stage.
  gdpg_height u_height (
    .clk_i     (clk_i),
    .inv_row_i (inv_row_q),
    .inv_col_i (inv_col_q),
    .peak_i    (peak_q),
    .height_o  (height)
  );

  assign prod_d = height * $signed({1'b0, g});

  // The arithmetic shift rounds the scaled term towards minus infinity.
  assign sum_w  = (PIX_W+2)'($signed(prod_q[PROD_W-1:16])) + (PIX_W+2)'(background_q);
  assign sat_hi = !sum_w[PIX_W+1] && (sum_w[PIX_W] || sum_w[PIX_W-1]);
  assign sat_lo = sum_w[PIX_W+1] && !(sum_w[PIX_W] && sum_w[PIX_W-1]);

  always_comb begin
    if (sat_hi) begin
      value_d = PIX_MAX;
    end else if (sat_lo) begin
      value_d = PIX_MIN;
    end else begin
      value_d = sum_w[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    value_q <= value_d;
    sat_q   <= sat_hi || sat_lo;
  end

  assign res_valid_o               = valid_q[LAT-1];
  assign res_o.pixel_value         = value_q;
  assign res_o.saturated           = sat_q;
  assign res_o.last_in_row         = flags_q[LAT-1].last_in_row;
  assign res_o.last_in_frame       = flags_q[LAT-1].last_in_frame;

  a_result_has_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, LAT))
    else $error("result strobe without a pixel accepted nine cycles earlier");

  a_pixel_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT res_valid_o)
    else $error("accepted pixel produced no result");

  a_sat_clips : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.saturated) |->
      (res_o.pixel_value == PIX_MAX || res_o.pixel_value == PIX_MIN))
    else $error("saturation flag set on an unclipped value");

  a_frame_end_is_row_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!res_o.last_in_frame || res_o.last_in_row))
    else $error("end of frame flagged away from the end of a row");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_2d_pixel_generator: directed and random pixels
// under several register settings, checked against an in-bench fixed-point predictor.
// Depends on gdpg_pkg and the generator RTL only.
module tb_top;
  import gdpg_pkg::*;

  localparam int FRAC_ENTRIES = EXP_TABLE_SIZE_DEF;
  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 12;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_PIXELS = 32;

  // Holds a copy of the registers, predicts each pixel and compares what comes out.
  class gauss_scoreboard;
    bit [CENTRE_W-1:0] centre_row, centre_col;
    bit [INV_W-1:0]    inv_row, inv_col;
    bit [PIX_W-1:0]    height_reg, bg_reg;
    bit [DIM_W-1:0]    ncols, nrows;
    bit [EXP_W-1:0]    frac_rom[FRAC_ENTRIES];
    pix_out_t          expected_q[$];
    int n_checked, n_errors, n_sat, n_row_end, n_frame_end;

    function new();
      bit [63:0] xq, a, term, acc;
      centre_row = '0;
      centre_col = '0;
      inv_row    = 24'h010000;
      inv_col    = 24'h010000;
      height_reg = '0;
      bg_reg     = '0;
      ncols      = 13'd4096;
      nrows      = 13'd4096;
      // Table of 2^(-i/N) in Q.16, from a series of exp(-x*ln2) in Q.32.
      for (int i = 0; i < FRAC_ENTRIES; i++) begin
        xq   = (64'(i) << 32) / 64'(FRAC_ENTRIES);
        a    = (xq * LN2_Q32) >> 32;
        term = 64'd1 << 32;
        acc  = term;
        for (int n = 1; n <= 24; n++) begin
          term = ((term * a) >> 32) / 64'(n);
          if (n % 2 == 1) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
        frac_rom[i] = EXP_W'((acc + 64'd32768) >> 16);
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CENTER_ROW:    centre_row = data[CENTRE_W-1:0];
        REG_CENTER_COL:    centre_col = data[CENTRE_W-1:0];
        REG_INV_SIGMA_ROW: inv_row    = data[INV_W-1:0];
        REG_INV_SIGMA_COL: inv_col    = data[INV_W-1:0];
        REG_PEAK_HEIGHT:   height_reg = data;
        REG_BACKGROUND:    bg_reg     = data;
        REG_NUM_COLS:      ncols      = data[DIM_W-1:0];
        REG_NUM_ROWS:      nrows      = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Distance from the centre along one axis in units of sigma, Q.16, clipped at 16.0.
    function bit [63:0] axis_dist(bit [COORD_W-1:0] coord, bit [CENTRE_W-1:0] centre,
                                  bit [INV_W-1:0] inv);
      longint    d;
      bit [63:0] ad, z;
      d  = longint'({coord, 8'h00}) - longint'($signed(centre));
      ad = (d < 0) ? 64'(-d) : 64'(d);
      z  = (ad * 64'(inv)) >> 8;
      return (z > 64'(Z_CLIP)) ? 64'(Z_CLIP) : z;
    endfunction

    function void note_pixel(pix_in_t p);
      bit [63:0] zy, zx, t, e, k, f, g, pp, h;
      longint    hgt, prod, total;
      pix_out_t  r;
      zy = axis_dist(p.row, centre_row, inv_row);
      zx = axis_dist(p.col, centre_col, inv_col);
      t  = (zy * zy + zx * zx) >> 17;
      e  = (t * 64'(LOG2E_Q16)) >> 16;
      k  = e >> 16;
      f  = e & 64'hFFFF;
      g  = 64'(frac_rom[(f * 64'(FRAC_ENTRIES)) >> 16]);
      g  = (k >= 32) ? 64'd0 : (g >> k);

      hgt = longint'($signed(height_reg));
      if (hgt == 0) begin
        // Unit-integral height: inv_sy * inv_sx / (2*pi)
        pp  = 64'(inv_row) * 64'(inv_col);
        h   = (pp >> 16) * 64'(INV_2PI_Q32) + (((pp & 64'hFFFF) * 64'(INV_2PI_Q32)) >> 16);
        hgt = longint'(h >> 32);
      end
      prod  = hgt * longint'(g);
      total = (prod >>> 16) + longint'($signed(bg_reg));

      r.saturated = 1'b0;
      if (total > longint'(PIX_MAX)) begin
        total       = longint'(PIX_MAX);
        r.saturated = 1'b1;
      end
      if (total < longint'(PIX_MIN)) begin
        total       = longint'(PIX_MIN);
        r.saturated = 1'b1;
      end
      r.pixel_value   = total[PIX_W-1:0];
      r.last_in_row   = (ncols >= 1) && (ncols <= MAX_DIM) &&
                        ({1'b0, p.col} == ncols - 13'd1);
      r.last_in_frame = r.last_in_row && (nrows >= 1) && (nrows <= MAX_DIM) &&
                        ({1'b0, p.row} == nrows - 13'd1);
      n_sat       += r.saturated;
      n_row_end   += r.last_in_row;
      n_frame_end += r.last_in_frame;
      expected_q.push_back(r);
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with none pending: expected nothing, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.pixel_value !== want.pixel_value) begin
        n_errors++;
        $display("%0t: pixel_value expected %h actual %h", $time,
                 want.pixel_value, got.pixel_value);
      end
      if (got.saturated !== want.saturated) begin
        n_errors++;
        $display("%0t: saturated expected %b actual %b", $time, want.saturated, got.saturated);
      end
      if (got.last_in_row !== want.last_in_row) begin
        n_errors++;
        $display("%0t: last_in_row expected %b actual %b", $time,
                 want.last_in_row, got.last_in_row);
      end
      if (got.last_in_frame !== want.last_in_frame) begin
        n_errors++;
        $display("%0t: last_in_frame expected %b actual %b", $time,
                 want.last_in_frame, got.last_in_frame);
      end
    endfunction
  endclass

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  pix_in_t               pix_i      = '0;
  logic                  res_valid_o;
  pix_out_t              res_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gauss_scoreboard sb = new();
  int n_settings  = 0;
  int quiet_count = 0;

  gaussian_2d_pixel_generator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pix_i      (pix_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      sb.check_result(res_o);
    end
  end

  // Ends the run if nothing at all is accepted for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || cfg_we_i) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count == STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, sb.expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic pix_in_t px(int r, int c);
    pix_in_t p;
    p.row = COORD_W'(r);
    p.col = COORD_W'(c);
    return p;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
  endfunction

  // Mostly pixels around the peak, some on the frame edges, the rest anywhere.
  function automatic pix_in_t make_pixel();
    int sel, spread_r, spread_c, cr, cc, r, c;
    sel      = $urandom_range(0, 99);
    cr       = int'($signed(sb.centre_row)) >>> 8;
    cc       = int'($signed(sb.centre_col)) >>> 8;
    spread_r = (sb.inv_row == 0) ? 4095 : 196608 / int'(sb.inv_row) + 2;
    spread_c = (sb.inv_col == 0) ? 4095 : 196608 / int'(sb.inv_col) + 2;
    spread_r = (spread_r > 4095) ? 4095 : spread_r;
    spread_c = (spread_c > 4095) ? 4095 : spread_c;
    if (sel < 60) begin
      r = clamp_coord(cr + $urandom_range(0, 2 * spread_r) - spread_r);
      c = clamp_coord(cc + $urandom_range(0, 2 * spread_c) - spread_c);
    end else if (sel < 80) begin
      r = (sb.nrows >= 1 && $urandom_range(0, 1)) ? int'(sb.nrows) - 1
                                                  : $urandom_range(0, 4095);
      c = (sb.ncols >= 1) ? int'(sb.ncols) - 1 : $urandom_range(0, 4095);
    end else begin
      r = $urandom_range(0, 4095);
      c = $urandom_range(0, 4095);
    end
    return px(r, c);
  endfunction

  function automatic int pick_gap(bit no_gaps);
    int sel;
    sel = $urandom_range(0, 99);
    if (no_gaps || sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_pixel(input pix_in_t p);
    @(negedge clk_i);
    start = 1'b1;
    pix_i = p;
    do @(posedge clk_i); while (busy);
    sb.note_pixel(p);
  endtask

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
      pix_i = pix_in_t'((2*COORD_W)'($urandom));
    end
  endtask

  // Lowers start and waits until every outstanding result has come back.
  task automatic drain();
    idle(1);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = d;
    sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_config(input logic [31:0] cr, input logic [31:0] cc,
                              input logic [31:0] ir, input logic [31:0] ic,
                              input logic [31:0] h, input logic [31:0] b,
                              input logic [31:0] nc, input logic [31:0] nr);
    write_reg(REG_CENTER_ROW, cr);
    write_reg(REG_CENTER_COL, cc);
    write_reg(REG_INV_SIGMA_ROW, ir);
    write_reg(REG_INV_SIGMA_COL, ic);
    write_reg(REG_PEAK_HEIGHT, h);
    write_reg(REG_BACKGROUND, b);
    write_reg(REG_NUM_COLS, nc);
    write_reg(REG_NUM_ROWS, nr);
    n_settings++;
  endtask

  function automatic logic [31:0] rand_inv();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'd0;
    if (sel == 1) return 32'h00FF_FFFF;
    if (sel == 2) return $urandom;
    return $urandom_range(256, 262143);
  endfunction

  function automatic logic [31:0] rand_level(int zero_pct);
    int sel, v;
    sel = $urandom_range(0, 99);
    if (sel < zero_pct) return 32'd0;
    if (sel < zero_pct + 5) return 32'h7FFF_FFFF;
    if (sel < zero_pct + 10) return 32'h8000_0000;
    v = $urandom;
    return v >>> $urandom_range(4, 20);
  endfunction

  function automatic logic [31:0] rand_dim();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(1, 64);
    if (sel < 7) return 32'd4096;
    if (sel == 7) return 32'd0;
    if (sel == 8) return $urandom_range(4097, 8191);
    return $urandom_range(1, 4096);
  endfunction

  function automatic logic [31:0] rand_centre();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h000F_FFFF;  // most positive
    if (sel == 1) return 32'h0010_0000;  // most negative
    if (sel == 2) return $urandom;
    return $urandom_range(0, 4095 * 256 + 255);
  endfunction

  initial begin
    bit no_gaps;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: normalised height, unit sigmas, peak at the origin.
    send_pixel(px(0, 0));
    send_pixel(px(0, 1));
    send_pixel(px(3, 4));
    send_pixel(px(4095, 4095));
    send_pixel(px(4095, 0));
    send_pixel(px(0, 4095));
    drain();

    // Positive overflow, a row axis with infinite sigma, one-pixel frame.
    apply_config(32'h0000_0580, 32'hFFFF_FFFF, 32'd0, 32'h00FF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1);
    send_pixel(px(0, 0));
    send_pixel(px(7, 0));
    send_pixel(px(0, 1));
    drain();

    // Extreme centres, infinite sigmas with normalised height, flags disabled.
    apply_config(32'h0010_0000, 32'h000F_FFFF, 32'd0, 32'd0,
                 32'd0, 32'h8000_0000, 32'd0, 32'd8191);
    send_pixel(px(0, 0));
    send_pixel(px(4095, 4095));
    drain();

    // Negative overflow at the peak.
    apply_config(32'd100 << 8, 32'd200 << 8, 32'h0000_4000, 32'h0000_4000,
                 32'h8000_0000, 32'h8000_0000, 32'd4096, 32'd4096);
    send_pixel(px(100, 200));
    send_pixel(px(100, 201));
    send_pixel(px(101, 203));
    send_pixel(px(4095, 4095));
    send_pixel(px(120, 180));
    drain();

    // Negative height rounds towards minus infinity; small frame for both flags.
    apply_config(32'h0000_0180, 32'h0000_0080, 32'h0001_8000, 32'h0000_C000,
                 -32'sd184263, -32'sd70000, 32'd2, 32'd3);
    send_pixel(px(2, 1));
    send_pixel(px(1, 1));
    send_pixel(px(2, 0));
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      apply_config(rand_centre(), rand_centre(), rand_inv(), rand_inv(),
                   rand_level(25), rand_level(30), rand_dim(), rand_dim());
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        send_pixel(make_pixel());
        idle(pick_gap(no_gaps));
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d pixels under %0d register settings besides the reset one.",
             sb.n_checked, n_settings);
    $display("Saturated: %0d, row ends: %0d, frame ends: %0d, mismatches: %0d.",
             sb.n_sat, sb.n_row_end, sb.n_frame_end, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
